### rtl/core/tsfp_pkg.sv
// Shared types and constants for the tile set file parser.
// Holds the phase, kind and status codes and the front-to-back event record.
// No dependencies.
package tsfp_pkg;

	// Fixed file layout
	localparam int unsigned SUBTILES_PER_METATILE = 4;
	localparam int unsigned COLORS_PER_PALETTE = 16;

	localparam logic [3:0] HDR_BYTES = 4'd8;
	localparam logic [3:0] CNT_BYTES = 4'd4;
	localparam logic [3:0] SUB_BYTES = 4'(SUBTILES_PER_METATILE * 2);
	localparam logic [3:0] META_BYTES = 4'(SUBTILES_PER_METATILE * 2 + 5);
	localparam logic [3:0] RGB_BYTES = 4'd3;
	localparam logic [3:0] LAST_COLOR = 4'(COLORS_PER_PALETTE - 1);
	localparam logic [7:0] MAX_ROW = 8'd7;

	// Parse phase
	typedef enum logic [1:0] {
		PH_SIG     = 2'd0,
		PH_META    = 2'd1,
		PH_PALHDR  = 2'd2,
		PH_PALDATA = 2'd3
	} phase_t;

	// Result kind
	typedef enum logic [2:0] {
		KIND_SUBTILE = 3'd0,
		KIND_ATTR    = 3'd1,
		KIND_COLOR   = 3'd2,
		KIND_ERROR   = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	// Result status
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_CLAMP        = 3'd1,
		ST_SHORT        = 3'd2,
		ST_BADSIG       = 3'd3,
		ST_TRUNC_META   = 3'd4,
		ST_TRUNC_ATTR   = 3'd5,
		ST_TRUNC_PALHDR = 3'd6,
		ST_TRUNC_PALDAT = 3'd7
	} status_t;

	// Classified event from the front. payload by kind:
	//   subtile: [15:0] raw word
	//   attr:    [15:0] behavior, [23:16] collision, [31:24] raw row, [39:32] reserved
	//   color:   [23:0] packed rgb
	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [31:0] rec_idx;
		logic [3:0]  sub_idx;
		logic [39:0] payload;
		status_t     status;
	} event_t;

	// Expected signature "AM95"
	function automatic logic [7:0] sig_byte(input logic [1:0] pos);
		logic [7:0] res;
		case (pos)
			2'd0: res = 8'h41;
			2'd1: res = 8'h4D;
			2'd2: res = 8'h39;
			default: res = 8'h35;
		endcase
		return res;
	endfunction

endpackage

### rtl/core/tsfp_front.sv
// Front of the parser: tracks file structure byte by byte and classifies
// each accepted byte into at most one event. Depends on tsfp_pkg.
module tsfp_front import tsfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_fire,
	input  logic [7:0]   data_byte,
	input  logic         end_of_file,
	output logic         ev_push,
	output event_t       ev
);

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [31:0] total_q, total_d;
	logic [31:0] rec_q, rec_d;
	logic [3:0]  color_q, color_d;
	logic [31:0] asm_q, asm_d;
	logic        sig_bad_q, sig_bad_d;
	logic        finished_q, finished_d;

	logic [3:0]  pos_inc;
	logic [31:0] rec_inc;
	logic [31:0] lane_word;

	assign pos_inc = pos_q + 4'd1;
	assign rec_inc = rec_q + 32'd1;
	// little-endian byte placed at lane pos[1:0]
	assign lane_word = asm_q | ({24'd0, data_byte} << {pos_q[1:0], 3'b000});

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIG;
			pos_q      <= '0;
			total_q    <= '0;
			rec_q      <= '0;
			color_q    <= '0;
			asm_q      <= '0;
			sig_bad_q  <= 1'b0;
			finished_q <= 1'b0;
		end else if (byte_fire) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			total_q    <= total_d;
			rec_q      <= rec_d;
			color_q    <= color_d;
			asm_q      <= asm_d;
			sig_bad_q  <= sig_bad_d;
			finished_q <= finished_d;
		end
	end

	// Next state and event
	always_comb begin
		logic    have;
		logic    fin;
		logic    err;
		status_t err_code;

		phase_d    = phase_q;
		pos_d      = pos_q;
		total_d    = total_q;
		rec_d      = rec_q;
		color_d    = color_q;
		asm_d      = asm_q;
		sig_bad_d  = sig_bad_q;
		finished_d = finished_q;
		ev         = '0;
		have       = 1'b0;
		fin        = 1'b0;
		err        = 1'b0;
		err_code   = ST_OK;

		if (!finished_q) begin
			case (phase_q)
				PH_SIG: begin
					if (pos_q < CNT_BYTES) begin
						if (data_byte != sig_byte(pos_q[1:0]))
							sig_bad_d = 1'b1;
					end else begin
						asm_d = lane_word;
					end
					pos_d = pos_inc;
					if (pos_inc >= HDR_BYTES) begin
						if (sig_bad_d) begin
							err      = 1'b1;
							err_code = ST_BADSIG;
						end else begin
							total_d = asm_d;
							rec_d   = '0;
							pos_d   = '0;
							asm_d   = '0;
							phase_d = (total_d != '0) ? PH_META : PH_PALHDR;
						end
					end
				end
				PH_META: begin
					if (pos_q < SUB_BYTES) begin
						if (!pos_q[0]) begin
							asm_d = {24'd0, data_byte};
						end else begin
							// second byte completes a subtile word
							ev.kind    = KIND_SUBTILE;
							ev.rec_idx = rec_q;
							ev.sub_idx = {2'b00, pos_q[2:1]};
							ev.payload = {24'd0, data_byte, asm_q[7:0]};
							have       = 1'b1;
						end
					end else if (pos_q < SUB_BYTES + CNT_BYTES) begin
						asm_d = (pos_q == SUB_BYTES) ? {24'd0, data_byte} : lane_word;
					end else begin
						// reserved byte completes the attributes
						ev.kind    = KIND_ATTR;
						ev.rec_idx = rec_q;
						ev.payload = {data_byte, asm_q};
						have       = 1'b1;
					end
					pos_d = pos_inc;
					if (pos_inc >= META_BYTES) begin
						pos_d = '0;
						asm_d = '0;
						rec_d = rec_inc;
						if (rec_inc == total_q) begin
							rec_d   = '0;
							phase_d = PH_PALHDR;
						end
					end
				end
				PH_PALHDR: begin
					asm_d = lane_word;
					pos_d = pos_inc;
					if (pos_inc >= CNT_BYTES) begin
						total_d = asm_d;
						rec_d   = '0;
						pos_d   = '0;
						asm_d   = '0;
						color_d = '0;
						if (lane_word == '0) begin
							ev.kind = KIND_END;
							have    = 1'b1;
							fin     = 1'b1;
						end else begin
							phase_d = PH_PALDATA;
						end
					end
				end
				default: begin
					// rgb bytes arrive big-endian into a 24-bit word
					asm_d = {8'd0, asm_q[15:0], data_byte};
					pos_d = pos_inc;
					if (pos_inc >= RGB_BYTES) begin
						ev.kind    = KIND_COLOR;
						ev.rec_idx = rec_q;
						ev.sub_idx = color_q;
						ev.payload = {16'd0, asm_d[23:0]};
						have       = 1'b1;
						pos_d      = '0;
						asm_d      = '0;
						if (color_q >= LAST_COLOR) begin
							color_d = '0;
							rec_d   = rec_inc;
							if (rec_inc == total_q)
								fin = 1'b1;
						end else begin
							color_d = color_q + 4'd1;
						end
					end
				end
			endcase

			// Early end of file: status follows the group that was cut
			if (!err && !fin && end_of_file) begin
				err = 1'b1;
				case (phase_d)
					PH_SIG:    err_code = ST_SHORT;
					PH_META:   err_code = (pos_d < SUB_BYTES) ? ST_TRUNC_META : ST_TRUNC_ATTR;
					PH_PALHDR: err_code = ST_TRUNC_PALHDR;
					default:   err_code = ST_TRUNC_PALDAT;
				endcase
			end
			if (err) begin
				ev        = '0;
				ev.kind   = KIND_ERROR;
				ev.status = err_code;
				have      = 1'b1;
				fin       = 1'b1;
			end
			if (fin) begin
				ev.fin     = 1'b1;
				finished_d = 1'b1;
			end
		end

		// Last byte of a file rearms the parser
		if (end_of_file) begin
			phase_d    = PH_SIG;
			pos_d      = '0;
			total_d    = '0;
			rec_d      = '0;
			color_d    = '0;
			asm_d      = '0;
			sig_bad_d  = 1'b0;
			finished_d = 1'b0;
		end

		ev_push = byte_fire && have;
	end

endmodule

### rtl/core/tsfp_queue.sv
// Short event queue between the parser front and the output back.
// Register-based, one write and one read port. Depends on tsfp_pkg.
module tsfp_queue import tsfp_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t wr_data,
	output logic   wr_ready,
	input  logic   pop,
	output event_t rd_data,
	output logic   rd_valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	event_t           entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign wr_ready = (cnt_q != FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/tsfp_back.sv
// Back of the parser: takes queued events, splits subtile words, clamps
// attribute rows and holds the result in the output register. Depends on tsfp_pkg.
module tsfp_back import tsfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ev_valid,
	input  event_t       ev,
	output logic         ev_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   kind,
	output logic         final_res,
	output logic [31:0]  record_index,
	output logic [3:0]   sub_index,
	output logic [9:0]   tile_index,
	output logic [2:0]   flags,
	output logic [2:0]   pal_row,
	output logic [23:0]  word_a,
	output logic [7:0]   byte_b,
	output logic [7:0]   byte_c,
	output logic [2:0]   status
);

	logic        valid_q;
	logic [2:0]  kind_q;
	logic        fin_q;
	logic [31:0] rec_q;
	logic [3:0]  sub_q;
	logic [9:0]  tile_q;
	logic [2:0]  flags_q;
	logic [2:0]  row_q;
	logic [23:0] word_a_q;
	logic [7:0]  byte_b_q;
	logic [7:0]  byte_c_q;
	logic [2:0]  status_q;

	logic [9:0]  tile_d;
	logic [2:0]  flags_d;
	logic [2:0]  row_d;
	logic [23:0] word_a_d;
	logic [7:0]  byte_b_d;
	logic [7:0]  byte_c_d;
	status_t     status_d;

	assign ev_pop = ev_valid && (!valid_q || out_ready);

	// Field decode per kind; unused fields stay zero
	always_comb begin
		tile_d   = '0;
		flags_d  = '0;
		row_d    = '0;
		word_a_d = '0;
		byte_b_d = '0;
		byte_c_d = '0;
		status_d = ev.status;
		case (ev.kind)
			KIND_SUBTILE: begin
				tile_d  = ev.payload[9:0];
				flags_d = {ev.payload[12], ev.payload[11], ev.payload[10]};
				row_d   = ev.payload[15:13];
			end
			KIND_ATTR: begin
				word_a_d = {8'd0, ev.payload[15:0]};
				byte_b_d = ev.payload[23:16];
				byte_c_d = ev.payload[39:32];
				if (ev.payload[31:24] > MAX_ROW) begin
					row_d    = MAX_ROW[2:0];
					status_d = ST_CLAMP;
				end else begin
					row_d = ev.payload[26:24];
				end
			end
			KIND_COLOR: begin
				word_a_d = ev.payload[23:0];
			end
			default: begin
				status_d = ev.status;
			end
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ev_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (ev_pop) begin
			kind_q   <= ev.kind;
			fin_q    <= ev.fin;
			rec_q    <= ev.rec_idx;
			sub_q    <= ev.sub_idx;
			tile_q   <= tile_d;
			flags_q  <= flags_d;
			row_q    <= row_d;
			word_a_q <= word_a_d;
			byte_b_q <= byte_b_d;
			byte_c_q <= byte_c_d;
			status_q <= status_d;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign final_res    = fin_q;
	assign record_index = rec_q;
	assign sub_index    = sub_q;
	assign tile_index   = tile_q;
	assign flags        = flags_q;
	assign pal_row      = row_q;
	assign word_a       = word_a_q;
	assign byte_b       = byte_b_q;
	assign byte_c       = byte_c_q;
	assign status       = status_q;

endmodule

### rtl/core/tile_set_file_parser.sv
// Tile set file parser, top level. Instantiates tsfp_front, tsfp_queue and
// tsfp_back; depends on tsfp_pkg.
//
// Takes a tile set file one byte per word, last byte marked by end_of_file,
// and emits one decoded word per subtile, per metatile attribute group and per
// palette color, then an end marker if the palette count is zero, or an error;
// final_res marks the last word of a parse, and a consumer drops the records
// of a parse that ends in error. Bytes after the final word are ignored until
// the next end_of_file. One byte is taken per clock cycle while in_ready is
// high: the front decodes it in the cycle it is accepted, and the result passes
// through a QUEUE_DEPTH-entry queue into the output register. in_ready falls
// only while that queue is full, which with a QUEUE_DEPTH of two or more
// happens only when the output side stalls.
module tile_set_file_parser import tsfp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         end_of_file,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   kind,
	output logic         final_res,
	output logic [31:0]  record_index,
	output logic [3:0]   sub_index,
	output logic [9:0]   tile_index,
	output logic [2:0]   flags,
	output logic [2:0]   pal_row,
	output logic [23:0]  word_a,
	output logic [7:0]   byte_b,
	output logic [7:0]   byte_c,
	output logic [2:0]   status
);

	logic   byte_fire;
	logic   ev_push;
	event_t ev_in;
	logic   q_ready;
	logic   q_valid;
	logic   q_pop;
	event_t q_data;

	assign in_ready  = q_ready;
	assign byte_fire = in_valid && q_ready;

	// Structure tracking and classification
	tsfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_fire   (byte_fire),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.ev_push     (ev_push),
		.ev          (ev_in)
	);

	// Decoupling queue
	tsfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_push),
		.wr_data  (ev_in),
		.wr_ready (q_ready),
		.pop      (q_pop),
		.rd_data  (q_data),
		.rd_valid (q_valid)
	);

	// Field decode and output register
	tsfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (q_valid),
		.ev           (q_data),
		.ev_pop       (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.final_res    (final_res),
		.record_index (record_index),
		.sub_index    (sub_index),
		.tile_index   (tile_index),
		.flags        (flags),
		.pal_row      (pal_row),
		.word_a       (word_a),
		.byte_b       (byte_b),
		.byte_c       (byte_c),
		.status       (status)
	);

	// A classified event is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> q_ready)
		else $error("event pushed into full queue");

	// The back only pops what the queue holds
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// Errors and end markers close the parse and carry no record number
	a_terminal_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ERROR || kind == KIND_END)
			|-> final_res && record_index == '0)
		else $error("terminal word without final mark or with record number");

	// A word coming out of the back matches the event popped in the previous cycle
	a_kind_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid && kind == $past(q_data.kind) && final_res == $past(q_data.fin))
		else $error("output word does not match popped event");

endmodule
